>>> rtl/htma_pkg.sv
package htma_pkg;

  localparam int RAW_W  = 16;
  localparam int OFS_W  = 13;
  localparam int TEMP_W = 17;
  localparam int HUM_W  = 16;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_TEMP_OFS = 1'b0,
    CFG_HUM_OFS  = 1'b1
  } cfg_idx_t;

  localparam logic signed [OFS_W-1:0] TEMP_OFS_RST = -13'sd256;
  localparam logic signed [OFS_W-1:0] HUM_OFS_RST  = 13'sd1280;

  localparam logic [7:0]  TEMP_GAIN = 8'd165;
  localparam logic [7:0]  HUM_GAIN  = 8'd100;
  localparam logic [17:0] TEMP_BIAS = 18'd10240;   // 40 degrees in 1/256 units

  typedef struct packed {
    logic load;      // converted sample captured into the lane
    logic advance;   // lane sample enters the window, sum updates
  } lane_ctl_t;

  // raw*165/256 - 40*256 + offset; fits 17 bits signed for any offset
  function automatic logic signed [TEMP_W-1:0] temp_conv(
    input logic [RAW_W-1:0] raw,
    input logic signed [OFS_W-1:0] ofs
  );
    logic [RAW_W+7:0] prod;
    logic signed [17:0] val;
    prod = raw * TEMP_GAIN;
    val  = $signed({1'b0, prod[RAW_W+7:8]}) - $signed(TEMP_BIAS) + 18'(ofs);
    return val[TEMP_W-1:0];
  endfunction

  // raw*100/256 + offset; fits 16 bits signed for any offset
  function automatic logic signed [HUM_W-1:0] hum_conv(
    input logic [RAW_W-1:0] raw,
    input logic signed [OFS_W-1:0] ofs
  );
    logic [RAW_W+7:0] prod;
    logic signed [16:0] val;
    prod = raw * HUM_GAIN;
    val  = $signed({1'b0, prod[RAW_W+7:8]}) + 17'(ofs);
    return val[HUM_W-1:0];
  endfunction

endpackage

>>> rtl/htma_lane.sv
module htma_lane #(
  parameter int WINDOW = 32,
  parameter int VAL_W  = 17
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  htma_pkg::lane_ctl_t     ctl,
  input  logic signed [VAL_W-1:0] conv_in,
  output logic signed [VAL_W-1:0] mean
);

  localparam int AW    = $clog2(WINDOW);
  localparam int SUM_W = VAL_W + $clog2(WINDOW);
  localparam int SHIFT = $clog2(WINDOW + 1) - 1;   // floor(log2(WINDOW))

  logic signed [VAL_W-1:0] mem [WINDOW];

  logic signed [VAL_W-1:0] conv_r;
  logic signed [VAL_W-1:0] rd_r;
  logic [AW-1:0]           ptr_r, ptr_nxt;
  logic                    wrapped_r, wrapped_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [VAL_W-1:0] oldest;
  logic                    ptr_last;

  assign ptr_last = (ptr_r == AW'(WINDOW - 1));

  always_comb begin
    ptr_nxt     = ptr_r;
    wrapped_nxt = wrapped_r;
    if (ctl.advance) begin
      ptr_nxt = ptr_last ? '0 : ptr_r + AW'(1);
      if (ptr_last) begin
        wrapped_nxt = 1'b1;
      end
    end
  end

  // before the first lap the oldest slot was never written: reads as zero
  assign oldest  = wrapped_r ? rd_r : '0;
  assign sum_nxt = sum_r + SUM_W'(conv_r) - SUM_W'(oldest);
  assign mean    = VAL_W'(sum_nxt >>> SHIFT);

  // read port prefetches the slot that the next beat will retire
  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      mem[ptr_r] <= conv_r;
    end
    rd_r <= mem[ptr_nxt];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      conv_r <= conv_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      wrapped_r <= 1'b0;
      sum_r     <= '0;
    end else begin
      ptr_r     <= ptr_nxt;
      wrapped_r <= wrapped_nxt;
      if (ctl.advance) begin
        sum_r <= sum_nxt;
      end
    end
  end

endmodule

>>> rtl/humidity_temperature_moving_average_top.sv
// Channel  Dir  Beat contents
// in_      in   tdata: raw_temperature[15:0], raw_humidity[31:16]
// out_     out  tdata: mean_temperature[16:0], mean_humidity[32:17], zero pad[39:33]
// cfg_     in   index 0 temperature_offset, index 1 humidity_offset (13-bit signed)
//
// One beat per cycle sustained while out_tready stays high.
// Stages: conversion register, then window/sum update (one write, one read port per lane) into the output register.
// Synchronous active-low reset clears sums, pointers and valid bits; window memory
// contents read as zero until the pointer completes its first lap, so no clearing pass.
// A stalled out_ backs up through the stages; in_tready stays high while a stage is free.
module humidity_temperature_moving_average_top #(
  parameter int WINDOW = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // raw_temperature, raw_humidity
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // mean_temperature, mean_humidity, pad
  input  logic        cfg_wen,
  input  logic [0:0]  cfg_index,
  input  logic [12:0] cfg_wdata
);

  logic signed [htma_pkg::OFS_W-1:0] temp_ofs_r, hum_ofs_r;

  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;
  htma_pkg::lane_ctl_t ctl;

  logic signed [htma_pkg::TEMP_W-1:0] temp_conv, temp_mean, temp_mean_r;
  logic signed [htma_pkg::HUM_W-1:0]  hum_conv, hum_mean, hum_mean_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_ofs_r <= htma_pkg::TEMP_OFS_RST;
      hum_ofs_r  <= htma_pkg::HUM_OFS_RST;
    end else if (cfg_wen) begin
      unique case (htma_pkg::cfg_idx_t'(cfg_index))
        htma_pkg::CFG_TEMP_OFS: temp_ofs_r <= cfg_wdata;
        htma_pkg::CFG_HUM_OFS:  hum_ofs_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_free    = !out_valid_r || out_tready;
  assign ctl.advance = s1_valid_r && out_free;
  assign in_tready   = !s1_valid_r || ctl.advance;
  assign ctl.load    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (ctl.load) begin
      s1_valid_nxt = 1'b1;
    end else if (ctl.advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (ctl.advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign temp_conv = htma_pkg::temp_conv(in_tdata[15:0], temp_ofs_r);
  assign hum_conv  = htma_pkg::hum_conv(in_tdata[31:16], hum_ofs_r);

  htma_lane #(
    .WINDOW (WINDOW),
    .VAL_W  (htma_pkg::TEMP_W)
  ) u_temp_lane (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .conv_in (temp_conv),
    .mean    (temp_mean)
  );

  htma_lane #(
    .WINDOW (WINDOW),
    .VAL_W  (htma_pkg::HUM_W)
  ) u_hum_lane (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .conv_in (hum_conv),
    .mean    (hum_mean)
  );

  // merge: both lanes retire together into one output beat
  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      temp_mean_r <= temp_mean;
      hum_mean_r  <= hum_mean;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, hum_mean_r, temp_mean_r};

endmodule
